// File: hdl/midpoint_ellipse_quadrant_raster_unit_defines.svh
// Assertion macros for the ellipse raster unit.
`ifndef MIDPOINT_ELLIPSE_QUADRANT_RASTER_UNIT_DEFINES_SVH
`define MIDPOINT_ELLIPSE_QUADRANT_RASTER_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define MEQR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("meqr check failed: same-cycle rule");

// Next-cycle implication, checked out of reset.
`define MEQR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("meqr check failed: next-cycle rule");

`endif

// File: hdl/meqr_pkg.sv
`timescale 1ns / 1ps
package meqr_pkg;

    // axis saturation and run cap
    localparam logic [4:0] AXIS_MAX  = 5'd31;
    localparam int         RUN_LIMIT = 64;
    localparam int         CNT_W     = 7;

    // shared multiplier operand and product widths
    localparam int MUL_A_W = 13;
    localparam int MUL_B_W = 10;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // width of incremental terms and decision value
    localparam int TERM_W = 24;
    localparam int DEC_W  = 32;

    typedef struct packed {
        logic                 en;
        logic [MUL_A_W-1:0]   op_a;
        logic [MUL_B_W-1:0]   op_b;
    } mul_req_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_A,
        ST_SQ_B,
        ST_B_A,
        ST_INIT1,
        ST_REG1,
        ST_X_X,
        ST_B_XX,
        ST_Y_Y,
        ST_A_YY,
        ST_A_B,
        ST_INIT2,
        ST_REG2,
        ST_DONE
    } state_t;

endpackage

// File: hdl/meqr_mul.sv
`timescale 1ns / 1ps
module meqr_mul (
    input  logic                               clk,
    input  meqr_pkg::mul_req_t                 req,
    output logic [meqr_pkg::MUL_P_W-1:0]       prod
);
    import meqr_pkg::*;

    // registered product, loaded only when requested
    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            prod <= MUL_P_W'(req.op_a) * MUL_P_W'(req.op_b);
        end
    end

endmodule

// File: hdl/midpoint_ellipse_quadrant_raster_unit.sv
`timescale 1ns / 1ps
// Channel   | Ports                                   | Handshake
// ----------+-----------------------------------------+---------------------------------
// command   | semi_axis_x, semi_axis_y                | beat on start && !busy
// pixel     | pixel_x, pixel_y, in_region_two,        | one-cycle beat on pixel_valid,
//           | last_pixel                              | no back-pressure
//
// A command keeps busy high until its run ends; N, its pixel count, is at most 64.
// Setup computes three products, region two entry five more;
// the multiplier is the only one.
// Pixels leave through a hold stage and an output register, so a beat trails its step by both
// registers (the last region one pixel waits out region two entry as well), and
// the last beat (last_pixel = 1) comes out in the first cycle with busy low.
// rst_n is asynchronous and clears the sequencer, counters and strobes.
// The pixel receiver cannot stall; every beat is taken in the cycle it is shown.
module midpoint_ellipse_quadrant_raster_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [4:0] semi_axis_x,
    input  logic [4:0] semi_axis_y,
    output logic       pixel_valid,
    output logic [4:0] pixel_x,
    output logic [5:0] pixel_y,
    output logic       in_region_two,
    output logic       last_pixel
);
    import meqr_pkg::*;

    `include "midpoint_ellipse_quadrant_raster_unit_defines.svh"

    function automatic logic signed [DEC_W-1:0] dx(input logic signed [TERM_W-1:0] v);
        return {{(DEC_W-TERM_W){v[TERM_W-1]}}, v};
    endfunction

    state_t state_reg, state_next;

    logic [4:0]                 a_reg, a_next;
    logic [4:0]                 b_reg, b_next;
    logic [9:0]                 aa_reg, aa_next;
    logic [9:0]                 bb_reg, bb_next;
    logic signed [6:0]          x_reg, x_next;
    logic [6:0]                 y_reg, y_next;
    logic signed [TERM_W-1:0]   ta_reg, ta_next;   // 4*A*y
    logic signed [TERM_W-1:0]   tb_reg, tb_next;   // 4*B*x
    logic signed [DEC_W-1:0]    d_reg, d_next;
    logic [CNT_W-1:0]           n_reg, n_next;

    logic                       pend_valid_reg, pend_valid_next;
    logic [4:0]                 pend_x_reg, pend_x_next;
    logic [5:0]                 pend_y_reg, pend_y_next;
    logic                       pend_r2_reg, pend_r2_next;

    logic                       out_valid_reg, out_valid_next;
    logic [4:0]                 out_x_reg, out_x_next;
    logic [5:0]                 out_y_reg, out_y_next;
    logic                       out_r2_reg, out_r2_next;
    logic                       out_last_reg, out_last_next;

    mul_req_t                   mul_req;
    logic [MUL_P_W-1:0]         mul_q;

    logic                       accept;
    logic                       run_full;
    logic                       slope_hold;
    logic                       x_done;
    logic                       emit;
    logic signed [TERM_W-1:0]   aa_t, bb_t, mul_t;
    logic signed [TERM_W-1:0]   ta_inc, tb_dec;

    meqr_mul u_mul (
        .clk  (clk),
        .req  (mul_req),
        .prod (mul_q)
    );

    assign busy    = (state_reg != ST_IDLE);
    assign accept  = start && !busy;

    assign aa_t    = $signed({{(TERM_W-10){1'b0}}, aa_reg});
    assign bb_t    = $signed({{(TERM_W-10){1'b0}}, bb_reg});
    assign mul_t   = $signed({{(TERM_W-MUL_P_W){1'b0}}, mul_q});
    assign ta_inc  = ta_reg + (aa_t <<< 2);
    assign tb_dec  = tb_reg - (bb_t <<< 2);

    assign run_full   = (n_reg >= CNT_W'(RUN_LIMIT));
    assign slope_hold = (tb_reg > ta_reg);     // 2B*x > 2A*y
    assign x_done     = x_reg[6];              // x has passed 0

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (accept) state_next = ST_SQ_A;
            ST_SQ_A:  state_next = ST_SQ_B;
            ST_SQ_B:  state_next = ST_B_A;
            ST_B_A:   state_next = ST_INIT1;
            ST_INIT1: state_next = ST_REG1;
            ST_REG1:
            begin
                if (!slope_hold)
                    state_next = ST_X_X;
                else if (run_full)
                    state_next = ST_DONE;
            end
            ST_X_X:   state_next = ST_B_XX;
            ST_B_XX:  state_next = ST_Y_Y;
            ST_Y_Y:   state_next = ST_A_YY;
            ST_A_YY:  state_next = ST_A_B;
            ST_A_B:   state_next = ST_INIT2;
            ST_INIT2: state_next = ST_REG2;
            ST_REG2:  if (run_full || x_done) state_next = ST_DONE;
            ST_DONE:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // datapath and multiplier control
    always_comb
    begin
        a_next          = a_reg;
        b_next          = b_reg;
        aa_next         = aa_reg;
        bb_next         = bb_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        ta_next         = ta_reg;
        tb_next         = tb_reg;
        d_next          = d_reg;
        n_next          = n_reg;
        mul_req         = '0;
        emit            = 1'b0;
        pend_x_next     = pend_x_reg;
        pend_y_next     = pend_y_reg;
        pend_r2_next    = pend_r2_reg;
        pend_valid_next = pend_valid_reg;
        out_valid_next  = 1'b0;
        out_x_next      = out_x_reg;
        out_y_next      = out_y_reg;
        out_r2_next     = out_r2_reg;
        out_last_next   = out_last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    a_next = (semi_axis_x > AXIS_MAX) ? AXIS_MAX : semi_axis_x;
                    b_next = (semi_axis_y > AXIS_MAX) ? AXIS_MAX : semi_axis_y;
                    n_next = '0;
                end
            end
            ST_SQ_A:
            begin
                mul_req = '{en: 1'b1, op_a: MUL_A_W'(a_reg), op_b: MUL_B_W'(a_reg)};
            end
            ST_SQ_B:
            begin
                aa_next = mul_q[9:0];
                mul_req = '{en: 1'b1, op_a: MUL_A_W'(b_reg), op_b: MUL_B_W'(b_reg)};
            end
            ST_B_A:
            begin
                bb_next = mul_q[9:0];
                mul_req = '{en: 1'b1, op_a: mul_q[MUL_A_W-1:0], op_b: MUL_B_W'(a_reg)};
            end
            ST_INIT1:
            begin
                // the B*A products of the start term cancel: d = 2A - 2B*a + B/2
                d_next  = dx(aa_t <<< 1) - dx(mul_t <<< 1) + dx(bb_t >>> 1);
                tb_next = mul_t <<< 2;
                ta_next = '0;
                x_next  = $signed({2'b00, a_reg});
                y_next  = '0;
            end
            ST_REG1:
            begin
                if (slope_hold && !run_full)
                begin
                    emit         = 1'b1;
                    pend_x_next  = x_reg[4:0];
                    pend_y_next  = y_reg[5:0];
                    pend_r2_next = 1'b0;
                    y_next       = y_reg + 7'd1;
                    ta_next      = ta_inc;
                    if (d_reg[DEC_W-1])
                    begin
                        d_next = d_reg + dx(ta_inc + (aa_t <<< 1));
                    end
                    else
                    begin
                        x_next  = x_reg - 7'sd1;
                        tb_next = tb_dec;
                        d_next  = d_reg + dx(ta_inc - tb_dec + (aa_t <<< 1));
                    end
                end
            end
            ST_X_X:
            begin
                mul_req = '{en: 1'b1, op_a: MUL_A_W'(unsigned'(x_reg)),
                            op_b: MUL_B_W'(unsigned'(x_reg))};
            end
            ST_B_XX:
            begin
                mul_req = '{en: 1'b1, op_a: mul_q[MUL_A_W-1:0], op_b: bb_reg};
            end
            ST_Y_Y:
            begin
                // 2B*x*x + 2B - 4B*x + 2A*y + A/2, the y*y and A*B parts follow
                d_next  = dx(mul_t <<< 1) + dx(bb_t <<< 1) - dx(tb_reg)
                        + dx(ta_reg >>> 1) + dx(aa_t >>> 1);
                mul_req = '{en: 1'b1, op_a: MUL_A_W'(y_reg), op_b: MUL_B_W'(y_reg)};
            end
            ST_A_YY:
            begin
                mul_req = '{en: 1'b1, op_a: mul_q[MUL_A_W-1:0], op_b: aa_reg};
            end
            ST_A_B:
            begin
                d_next  = d_reg + dx(mul_t <<< 1);
                mul_req = '{en: 1'b1, op_a: MUL_A_W'(bb_reg), op_b: aa_reg};
            end
            ST_INIT2:
            begin
                d_next = d_reg - dx(mul_t <<< 1);
            end
            ST_REG2:
            begin
                if (!run_full && !x_done)
                begin
                    emit         = 1'b1;
                    pend_x_next  = x_reg[4:0];
                    pend_y_next  = y_reg[5:0];
                    pend_r2_next = 1'b1;
                    x_next       = x_reg - 7'sd1;
                    tb_next      = tb_dec;
                    if (d_reg[DEC_W-1])
                    begin
                        y_next  = y_reg + 7'd1;
                        ta_next = ta_inc;
                        d_next  = d_reg + dx(ta_inc - tb_dec + (bb_t <<< 1));
                    end
                    else
                    begin
                        d_next = d_reg + dx((bb_t <<< 1) - tb_dec);
                    end
                end
            end
            ST_DONE:
            begin
                // flush the held pixel as the final beat
                out_valid_next  = pend_valid_reg;
                out_x_next      = pend_x_reg;
                out_y_next      = pend_y_reg;
                out_r2_next     = pend_r2_reg;
                out_last_next   = 1'b1;
                pend_valid_next = 1'b0;
            end
            default:
            begin
                mul_req = '0;
            end
        endcase

        if (emit)
        begin
            // a new pixel pushes the held one out, which is then not the last
            n_next          = n_reg + CNT_W'(1);
            out_valid_next  = pend_valid_reg;
            out_x_next      = pend_x_reg;
            out_y_next      = pend_y_reg;
            out_r2_next     = pend_r2_reg;
            out_last_next   = 1'b0;
            pend_valid_next = 1'b1;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            n_reg          <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            n_reg          <= n_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        a_reg        <= a_next;
        b_reg        <= b_next;
        aa_reg       <= aa_next;
        bb_reg       <= bb_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        ta_reg       <= ta_next;
        tb_reg       <= tb_next;
        d_reg        <= d_next;
        pend_x_reg   <= pend_x_next;
        pend_y_reg   <= pend_y_next;
        pend_r2_reg  <= pend_r2_next;
        out_x_reg    <= out_x_next;
        out_y_reg    <= out_y_next;
        out_r2_reg   <= out_r2_next;
        out_last_reg <= out_last_next;
    end

    assign pixel_valid   = out_valid_reg;
    assign pixel_x       = out_x_reg;
    assign pixel_y       = out_y_reg;
    assign in_region_two = out_r2_reg;
    assign last_pixel    = out_last_reg;

    // a beat outside a command can only be the closing one
    `MEQR_ASSERT_NOW(a_idle_beat_is_last, clk, rst_n, pixel_valid && !busy, last_pixel)
    // an accepted command holds the unit busy
    `MEQR_ASSERT_NEXT(a_accept_sets_busy, clk, rst_n, accept, busy)
    // nothing follows the closing beat directly
    `MEQR_ASSERT_NEXT(a_last_then_quiet, clk, rst_n, pixel_valid && last_pixel, !pixel_valid)
    // the run counter never passes the cap
    `MEQR_ASSERT_NOW(a_run_capped, clk, rst_n, busy, n_reg <= CNT_W'(RUN_LIMIT))

endmodule

// File: verif/midpoint_ellipse_quadrant_raster_unit_test.sv
`timescale 1ns / 1ps
// Checks the ellipse quadrant rasterizer against a cycle-free model of the
// integer midpoint walk. Every accepted draw command is expanded here into its
// pixel list; each pixel beat from the block is matched in order against it.
module midpoint_ellipse_quadrant_raster_unit_test;

    import meqr_pkg::AXIS_MAX;
    import meqr_pkg::RUN_LIMIT;

    // Cycles with neither a command nor a pixel beat before the run is called hung.
    // Worst honest quiet spell: a sender gap plus setup and region two entry.
    localparam int QUIET_LIMIT  = 2000;
    // Cycles to watch for stray beats once nothing is pending.
    localparam int TAIL_CYCLES  = 20;
    localparam int IDLE_PERCENT = 12;
    localparam int MAX_GAP      = 90;
    localparam int PRINT_CAP    = 50;

    typedef struct packed {
        logic [4:0] x;
        logic [5:0] y;
        logic       region_two;
        logic       last;
    } pixel_t;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic [4:0] semi_axis_x;
    logic [4:0] semi_axis_y;
    logic       pixel_valid;
    logic [4:0] pixel_x;
    logic [5:0] pixel_y;
    logic       in_region_two;
    logic       last_pixel;

    // pixels still owed by the block, oldest first
    pixel_t expected_pixels[$];

    // our copy of the walker state as it stands after the last command
    logic [5:0]         walker_x;
    logic [5:0]         walker_y;
    logic signed [31:0] walker_decision;
    logic               walker_region;
    logic [9:0]         axis_x_sq;
    logic [9:0]         axis_y_sq;

    int  mismatch_count;
    int  commands_sent;
    int  quiet_cycles;
    bit  sender_idles;

    midpoint_ellipse_quadrant_raster_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .semi_axis_x   (semi_axis_x),
        .semi_axis_y   (semi_axis_y),
        .pixel_valid   (pixel_valid),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .in_region_two (in_region_two),
        .last_pixel    (last_pixel)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic pixel_t make_pixel(input longint px, input longint py, input bit r2);
        pixel_t p;
        p.x          = px[4:0];
        p.y          = py[5:0];
        p.region_two = r2;
        p.last       = 1'b0;
        return p;
    endfunction

    // Walk one quadrant and queue its pixels. All terms are 64-bit so nothing
    // wraps before the final masking to the port widths.
    task automatic predict_quadrant(input logic [4:0] ax, input logic [4:0] ay);
        longint a;
        longint b;
        longint aa;
        longint bb;
        longint x;
        longint y;
        longint d;
        int     n;
        bit     capped;
        pixel_t run[$];
        a = ax;
        b = ay;
        // saturation, unreachable with 5-bit ports but kept for parameter changes
        if (a > AXIS_MAX) a = AXIS_MAX;
        if (b > AXIS_MAX) b = AXIS_MAX;
        aa = a * a;
        bb = b * b;
        x = a;
        y = 0;
        n = 0;
        capped = 1'b0;

        // region one: y steps every pixel, x only when d >= 0
        d = 2 * bb * a * (a - 1) + bb / 2 + 2 * aa * (1 - bb);
        while (2 * bb * x > 2 * aa * y) begin
            if (n >= RUN_LIMIT) begin
                capped = 1'b1;
                break;
            end
            run.push_back(make_pixel(x, y, 1'b0));
            n++;
            if (d < 0) begin
                y++;
                d += 4 * aa * y + 2 * aa;
            end
            else begin
                x--;
                y++;
                d += -4 * bb * x + 4 * aa * y + 2 * aa;
            end
        end
        walker_region = 1'b0;

        // region two: x steps every pixel down through 0, y only when d < 0
        if (!capped) begin
            walker_region = 1'b1;
            d = 2 * bb * (x * x + 1) - 4 * bb * x + 2 * aa * (y * y + y - bb) + aa / 2;
            while (x >= 0) begin
                if (n >= RUN_LIMIT) break;
                run.push_back(make_pixel(x, y, 1'b1));
                n++;
                if (d < 0) begin
                    x--;
                    y++;
                    d += 4 * aa * y - 4 * bb * x + 2 * bb;
                end
                else begin
                    x--;
                    d += -4 * bb * x + 2 * bb;
                end
            end
        end

        if (n > 0) run[n-1].last = 1'b1;
        foreach (run[i]) expected_pixels.push_back(run[i]);

        walker_x        = x[5:0];
        walker_y        = y[5:0];
        walker_decision = d[31:0];
        axis_x_sq       = aa[9:0];
        axis_y_sq       = bb[9:0];
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("[%0t] mismatch on %s: got %0d, expected %0d (commands sent %0d)",
                     $realtime, what, got, want, commands_sent);
    endtask

    // One command beat. start stays high after acceptance; the next call either
    // holds it or drops it for a random gap, so it is never lowered and raised in
    // the same step.
    task automatic send_axes(input logic [4:0] ax, input logic [4:0] ay);
        @(negedge clk);
        if (sender_idles && $urandom_range(99) < IDLE_PERCENT) begin
            start <= 1'b0;
            repeat ($urandom_range(MAX_GAP, 1)) @(negedge clk);
        end
        start       <= 1'b1;
        semi_axis_x <= ax;
        semi_axis_y <= ay;
        do @(posedge clk); while (busy !== 1'b0);
        commands_sent++;
        predict_quadrant(ax, ay);
    endtask

    // Sender stands down until every owed pixel has shown up.
    task automatic wait_drained();
        @(negedge clk);
        start <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge clk);
    endtask

    function automatic logic [4:0] pick_axis();
        logic [4:0] v;
        // lean on the edges a quarter of the time
        case ($urandom_range(7))
            0:       v = 5'd0;
            1:       v = 5'd31;
            default: v = 5'($urandom_range(31));
        endcase
        return v;
    endfunction

    // Field extremes and the degenerate shapes:
    //  zero x axis -> lone (0,0) in region two
    //  zero y axis -> flat row at y = 0, all region two
    //  both zero, full circle, thin slivers in each direction
    task automatic test_axis_extremes();
        logic [4:0] xs[$] = '{5'd0, 5'd31, 5'd0, 5'd31, 5'd1, 5'd31, 5'd1, 5'd0,
                              5'd1, 5'd16, 5'd8, 5'd21, 5'd10, 5'd15, 5'd30, 5'd2,
                              5'd5, 5'd26};
        logic [4:0] ys[$] = '{5'd0, 5'd0, 5'd31, 5'd31, 5'd1, 5'd1, 5'd31, 5'd1,
                              5'd0, 5'd8, 5'd16, 5'd10, 5'd21, 5'd15, 5'd2, 5'd30,
                              5'd26, 5'd5};
        foreach (xs[i]) send_axes(xs[i], ys[i]);
    endtask

    // Sender pause: nothing new goes in until the block has fully emptied.
    task automatic test_drain_pause();
        repeat (4) begin
            send_axes(pick_axis(), pick_axis());
            send_axes(pick_axis(), pick_axis());
            wait_drained();
        end
    endtask

    // Commands held ready the moment busy drops, so the trailing last beat of one
    // run overlaps acceptance of the next.
    task automatic test_back_to_back();
        sender_idles = 1'b0;
        repeat (40) send_axes(pick_axis(), pick_axis());
        sender_idles = 1'b1;
    endtask

    task automatic test_random_axes();
        repeat (144) send_axes(pick_axis(), pick_axis());
    endtask

    // pixel beats: matched in arrival order against the prediction
    always @(posedge clk) begin
        pixel_t want;
        if (rst_n) begin
            if ($isunknown(pixel_valid)) begin
                report_mismatch("pixel_valid unknown", 0, 0);
            end
            else if (pixel_valid) begin
                if (expected_pixels.size() == 0) begin
                    report_mismatch("pixel beat with none pending", pixel_x, 0);
                end
                else begin
                    want = expected_pixels.pop_front();
                    if (pixel_x !== want.x)
                        report_mismatch("pixel_x", pixel_x, want.x);
                    if (pixel_y !== want.y)
                        report_mismatch("pixel_y", pixel_y, want.y);
                    if (in_region_two !== want.region_two)
                        report_mismatch("in_region_two", in_region_two, want.region_two);
                    if (last_pixel !== want.last)
                        report_mismatch("last_pixel", last_pixel, want.last);
                end
            end
        end
    end

    // watchdog: restarts on any command or pixel beat
    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || pixel_valid === 1'b1) begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[%0t] no beat for %0d cycles", $realtime, QUIET_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
        else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        rst_n          = 1'b0;
        start          = 1'b0;
        semi_axis_x    = 5'd0;
        semi_axis_y    = 5'd0;
        mismatch_count = 0;
        commands_sent  = 0;
        quiet_cycles   = 0;
        sender_idles   = 1'b1;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_axis_extremes();
        test_drain_pause();
        test_back_to_back();
        test_random_axes();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_pixels.size() != 0)
            report_mismatch("pixels never delivered", 0, expected_pixels.size());

        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
